// ===== hw/rtl/timecode_frame_converter_macros.svh =====
// Assertion macros for the timecode frame converter.
// Checks compile only when SYNTH is not defined; no other dependencies.
`ifndef TIMECODE_FRAME_CONVERTER_MACROS_SVH
`define TIMECODE_FRAME_CONVERTER_MACROS_SVH

`ifndef SYNTH
// Clocked check that is masked while reset is asserted.
`define TFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also runs during reset.
`define TFC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TFC_ASSERT(lbl, prop, msg)
`define TFC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/tfc_pkg.sv =====
// Shared types, constants and the divider step of the timecode frame converter.
// No dependencies.
package tfc_pkg;

    localparam int RATE_W  = 7;
    localparam int COUNT_W = 32;
    localparam int FIELD_W = 8;
    localparam int HOURS_W = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int FRAME_W = 7;
    localparam int TOTAL_W = 24;

    // Register stages after the input register; the last one drives the outputs.
    localparam int NUM_STAGES = 36;

    localparam logic CFG_NOMINAL_RATE = 1'b0;
    localparam logic CFG_DROP_FRAME   = 1'b1;

    localparam logic CMD_COUNT_TO_TC = 1'b0;
    localparam logic CMD_TC_TO_COUNT = 1'b1;

    typedef struct packed {
        logic        q_bit;
        logic [31:0] rem;
    } t_div_res;

    // Frame count to timecode lane.
    typedef struct packed {
        logic        cmd;
        logic [31:0] rem;
        logic [23:0] count;
        logic [4:0]  h;
        logic [2:0]  ten;
        logic        sub;
        logic [3:0]  unit;
        logic [5:0]  m;
        logic [5:0]  s;
    } t_lane_a;

    // Timecode to frame count lane.
    typedef struct packed {
        logic [7:0]  fv;
        logic [8:0]  sv;
        logic [8:0]  mv;
        logic [8:0]  hv;
        logic [5:0]  mr;
        logic [7:0]  q;
        logic [2:0]  mq;
        logic [23:0] ph;
        logic [23:0] pm;
        logic [23:0] pt;
        logic [23:0] ps;
        logic [23:0] count;
    } t_lane_b;

    // One restoring division step against an already shifted divisor.
    function automatic t_div_res f_div_step(input logic [31:0] rem, input logic [39:0] dsh);
        t_div_res res;
        if ({8'd0, rem} >= dsh) begin
            res.q_bit = 1'b1;
            res.rem   = rem - dsh[31:0];
        end else begin
            res.q_bit = 1'b0;
            res.rem   = rem;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tfc_in_if.sv =====
// Input channel of the timecode frame converter: valid, ready and one command.
// Depends on tfc_pkg for field widths.
interface tfc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [tfc_pkg::COUNT_W-1:0]  count_in;
    logic [tfc_pkg::FIELD_W-1:0]  hours_in;
    logic [tfc_pkg::FIELD_W-1:0]  minutes_in;
    logic [tfc_pkg::FIELD_W-1:0]  seconds_in;
    logic [tfc_pkg::FIELD_W-1:0]  frames_in;

    modport source (output valid, cmd, count_in, hours_in, minutes_in, seconds_in, frames_in,
                    input ready);
    modport sink   (input valid, cmd, count_in, hours_in, minutes_in, seconds_in, frames_in,
                    output ready);
endinterface

// ===== hw/rtl/tfc_out_if.sv =====
// Output channel of the timecode frame converter: valid, ready and one result.
// Depends on tfc_pkg for field widths.
interface tfc_out_if;
    logic                         valid;
    logic                         ready;
    logic [tfc_pkg::HOURS_W-1:0]  hours_out;
    logic [tfc_pkg::MIN_W-1:0]    minutes_out;
    logic [tfc_pkg::SEC_W-1:0]    seconds_out;
    logic [tfc_pkg::FRAME_W-1:0]  frames_out;
    logic [tfc_pkg::TOTAL_W-1:0]  count_out;

    modport source (output valid, hours_out, minutes_out, seconds_out, frames_out, count_out,
                    input ready);
    modport sink   (input valid, hours_out, minutes_out, seconds_out, frames_out, count_out,
                    output ready);
endinterface

// ===== hw/rtl/timecode_frame_converter.sv =====
// Timecode frame converter: frame count <-> hh:mm:ss:ff, non-drop or drop-frame.
// Depends on tfc_pkg, tfc_in_if, tfc_out_if and timecode_frame_converter_macros.svh.
//
// One transfer is accepted every cycle unless a result waits unaccepted at the output,
// and each yields one result (an input register and 36 pipeline stages, the last of
// which drives the outputs). The pipeline depth is set by the restoring divider chain:
// one quotient bit per divider stage against the frames per day, hour, ten minutes,
// minute and second. The whole pipeline advances together and holds while a result
// waits at the output. Rate settings pass through the setting registers and then the
// derived rate registers, and must only change while no transfer is in flight.
module timecode_frame_converter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [tfc_pkg::RATE_W-1:0]   i_cfg_data,
    tfc_in_if.sink                       i_req,
    tfc_out_if.source                    o_res
);
    import tfc_pkg::*;
`include "timecode_frame_converter_macros.svh"

    logic [RATE_W-1:0] r_nominal;
    logic              r_drop;

    logic [6:0]  r_rate;
    logic [3:0]  r_d;
    logic [12:0] r_fpm;
    logic [16:0] r_f10;
    logic [19:0] r_fph;
    logic [23:0] r_fpd;

    logic [6:0]  n_rate;
    logic [11:0] n_dprod;
    logic [3:0]  n_d;
    logic [12:0] n_fpm;
    logic [16:0] n_f10;
    logic [19:0] n_fph;
    logic [23:0] n_fpd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= 7'd30;
            r_drop    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOMINAL_RATE: r_nominal <= i_cfg_data;
                CFG_DROP_FRAME:   r_drop    <= i_cfg_data[0];
                default:          r_drop    <= r_drop;
            endcase
        end
    end

    // Drop count rate / 15 is taken as ((rate + 1) * 17) >> 8, exact for rates to 127.
    always_comb begin
        n_rate  = (r_nominal == 7'd0) ? 7'd1 : r_nominal;
        n_dprod = (12'(n_rate) + 12'd1) * 12'd17;
        n_d     = r_drop ? n_dprod[11:8] : 4'd0;
        n_fpm   = 13'(n_rate) * 13'd60 - 13'(n_d);
        n_f10   = 17'(n_fpm) * 17'd10 + 17'(n_d);
        n_fph   = 20'(n_f10) * 20'd6;
        n_fpd   = 24'(n_fph) * 24'd24;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 7'd30;
            r_d    <= 4'd0;
            r_fpm  <= 13'd1800;
            r_f10  <= 17'd18000;
            r_fph  <= 20'd108000;
            r_fpd  <= 24'd2592000;
        end else begin
            r_rate <= n_rate;
            r_d    <= n_d;
            r_fpm  <= n_fpm;
            r_f10  <= n_f10;
            r_fph  <= n_fph;
            r_fpd  <= n_fpd;
        end
    end

    logic    r_valid [0:NUM_STAGES];
    t_lane_a r_a     [0:NUM_STAGES];
    t_lane_b r_b     [0:NUM_STAGES];
    logic    advance;
    t_lane_a n_a0;
    t_lane_b n_b0;

    assign advance     = !r_valid[NUM_STAGES] || o_res.ready;
    assign i_req.ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (advance) begin
            r_valid[0] <= i_req.valid;
        end
    end

    always_comb begin
        n_a0     = '0;
        n_a0.cmd = i_req.cmd;
        n_a0.rem = i_req.count_in;
        n_b0     = '0;
        n_b0.fv  = i_req.frames_in;
        n_b0.sv  = 9'(i_req.seconds_in);
        n_b0.mv  = 9'(i_req.minutes_in);
        n_b0.hv  = 9'(i_req.hours_in);
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a[0] <= n_a0;
            r_b[0] <= n_b0;
        end
    end

    for (genvar j = 0; j < NUM_STAGES; j++) begin : g_stage
        t_lane_a  n_a;
        t_lane_b  n_b;
        t_div_res dv_a;
        t_div_res dv_b;

        // Lane A: count modulo day, then hours, tens of minutes, minutes, seconds.
        if (j < 16) begin : g_a_day
            localparam int SH = 15 - j;
            always_comb begin
                dv_a     = f_div_step(r_a[j].rem, 40'(r_fpd) << SH);
                n_a      = r_a[j];
                n_a.rem  = dv_a.rem;
            end
        end else if (j < 21) begin : g_a_hour
            localparam int SH = 20 - j;
            always_comb begin
                dv_a      = f_div_step(r_a[j].rem, 40'(r_fph) << SH);
                n_a       = r_a[j];
                n_a.rem   = dv_a.rem;
                n_a.h[SH] = dv_a.q_bit;
                if (j == 16) begin
                    n_a.count = r_a[j].rem[23:0];
                end
            end
        end else if (j < 24) begin : g_a_ten
            localparam int SH = 23 - j;
            always_comb begin
                dv_a        = f_div_step(r_a[j].rem, 40'(r_f10) << SH);
                n_a         = r_a[j];
                n_a.rem     = dv_a.rem;
                n_a.ten[SH] = dv_a.q_bit;
            end
        end else if (j == 24) begin : g_a_drop
            // Inside the dropped labels of a minute the minute unit stays zero.
            always_comb begin
                dv_a = '0;
                n_a  = r_a[j];
                if (r_a[j].rem >= 32'(r_d)) begin
                    n_a.rem = r_a[j].rem - 32'(r_d);
                    n_a.sub = 1'b1;
                end else begin
                    n_a.sub = 1'b0;
                end
            end
        end else if (j < 29) begin : g_a_unit
            localparam int SH = 28 - j;
            always_comb begin
                dv_a         = f_div_step(r_a[j].rem, 40'(r_fpm) << SH);
                n_a          = r_a[j];
                n_a.rem      = dv_a.rem;
                n_a.unit[SH] = dv_a.q_bit;
            end
        end else if (j == 29) begin : g_a_restore
            always_comb begin
                dv_a  = '0;
                n_a   = r_a[j];
                n_a.m = 6'(r_a[j].ten * 6'd10) + 6'(r_a[j].unit);
                if (r_a[j].sub) begin
                    n_a.rem = r_a[j].rem + 32'(r_d);
                end
            end
        end else begin : g_a_sec
            localparam int SH = 35 - j;
            always_comb begin
                dv_a      = f_div_step(r_a[j].rem, 40'(r_rate) << SH);
                n_a       = r_a[j];
                n_a.rem   = dv_a.rem;
                n_a.s[SH] = dv_a.q_bit;
            end
        end

        // Lane B: carry frames, seconds and minutes, wrap hours, then sum the count.
        if (j < 8) begin : g_b_frame
            localparam int SH = 7 - j;
            always_comb begin
                dv_b      = f_div_step(32'(r_b[j].fv), 40'(r_rate) << SH);
                n_b       = r_b[j];
                n_b.fv    = dv_b.rem[7:0];
                n_b.q[SH] = dv_b.q_bit;
            end
        end else if (j == 8) begin : g_b_sec_carry
            always_comb begin
                dv_b   = '0;
                n_b    = r_b[j];
                n_b.sv = r_b[j].sv + 9'(r_b[j].q);
                n_b.q  = '0;
            end
        end else if (j < 13) begin : g_b_sec
            localparam int SH = 12 - j;
            always_comb begin
                dv_b      = f_div_step(32'(r_b[j].sv), 40'd60 << SH);
                n_b       = r_b[j];
                n_b.sv    = dv_b.rem[8:0];
                n_b.q[SH] = dv_b.q_bit;
            end
        end else if (j == 13) begin : g_b_min_carry
            always_comb begin
                dv_b   = '0;
                n_b    = r_b[j];
                n_b.mv = r_b[j].mv + 9'(r_b[j].q);
                n_b.q  = '0;
            end
        end else if (j < 17) begin : g_b_min
            localparam int SH = 16 - j;
            always_comb begin
                dv_b      = f_div_step(32'(r_b[j].mv), 40'd60 << SH);
                n_b       = r_b[j];
                n_b.mv    = dv_b.rem[8:0];
                n_b.q[SH] = dv_b.q_bit;
            end
        end else if (j == 17) begin : g_b_hour_carry
            always_comb begin
                dv_b   = '0;
                n_b    = r_b[j];
                n_b.hv = r_b[j].hv + 9'(r_b[j].q);
                n_b.mr = r_b[j].mv[5:0];
                n_b.q  = '0;
            end
        end else if (j < 22) begin : g_b_hour
            localparam int SH = 21 - j;
            always_comb begin
                dv_b   = f_div_step(32'(r_b[j].hv), 40'd24 << SH);
                n_b    = r_b[j];
                n_b.hv = dv_b.rem[8:0];
            end
        end else if (j < 25) begin : g_b_tens
            localparam int SH = 24 - j;
            always_comb begin
                dv_b       = f_div_step(32'(r_b[j].mr), 40'd10 << SH);
                n_b        = r_b[j];
                n_b.mr     = dv_b.rem[5:0];
                n_b.mq[SH] = dv_b.q_bit;
            end
        end else if (j == 25) begin : g_b_mul
            always_comb begin
                dv_b   = '0;
                n_b    = r_b[j];
                n_b.ph = 24'(r_b[j].hv[4:0]) * 24'(r_fph);
                n_b.pm = 24'(r_b[j].mr[3:0]) * 24'(r_fpm);
                n_b.pt = 24'(r_b[j].mq) * 24'(r_f10);
                n_b.ps = 24'(r_b[j].sv[5:0]) * 24'(r_rate);
            end
        end else if (j == 26) begin : g_b_sum
            always_comb begin
                dv_b      = '0;
                n_b       = r_b[j];
                n_b.count = r_b[j].ph + r_b[j].pm + r_b[j].pt + r_b[j].ps + 24'(r_b[j].fv);
            end
        end else begin : g_b_hold
            always_comb begin
                dv_b = '0;
                n_b  = r_b[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (advance) begin
                r_valid[j+1] <= r_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_a[j+1] <= n_a;
                r_b[j+1] <= n_b;
            end
        end
    end

    logic out_cmd;
    logic out_tc;
    logic out_stall;
    assign out_cmd           = r_a[NUM_STAGES].cmd;
    assign out_tc            = r_valid[NUM_STAGES] && (out_cmd == CMD_TC_TO_COUNT);
    assign out_stall         = r_valid[NUM_STAGES] && !o_res.ready;
    assign o_res.valid       = r_valid[NUM_STAGES];
    assign o_res.hours_out   = (out_cmd == CMD_TC_TO_COUNT) ? r_b[NUM_STAGES].hv[4:0]
                                                            : r_a[NUM_STAGES].h;
    assign o_res.minutes_out = (out_cmd == CMD_TC_TO_COUNT) ? r_b[NUM_STAGES].mv[5:0]
                                                            : r_a[NUM_STAGES].m;
    assign o_res.seconds_out = (out_cmd == CMD_TC_TO_COUNT) ? r_b[NUM_STAGES].sv[5:0]
                                                            : r_a[NUM_STAGES].s;
    assign o_res.frames_out  = (out_cmd == CMD_TC_TO_COUNT) ? r_b[NUM_STAGES].fv[6:0]
                                                            : r_a[NUM_STAGES].rem[6:0];
    assign o_res.count_out   = (out_cmd == CMD_TC_TO_COUNT) ? r_b[NUM_STAGES].count
                                                            : r_a[NUM_STAGES].count;

    `TFC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_res.valid, "result valid right after reset")
    `TFC_ASSERT(a_tc_hours, out_tc |-> (r_b[NUM_STAGES].hv < 9'd24), "hours not wrapped")
    `TFC_ASSERT(a_tc_minutes, out_tc |-> (r_b[NUM_STAGES].mv < 9'd60), "minute carry missed")
    `TFC_ASSERT(a_tc_seconds, out_tc |-> (r_b[NUM_STAGES].sv < 9'd60), "second carry missed")
    `TFC_ASSERT(a_hold_on_stall, out_stall |=> $stable(o_res.count_out), "result moved in a stall")

endmodule
